// ----- hw/rtl/json_token_expiry_extractor_macros.svh -----
// Assertion macros used by the checker of the token and expiry extractor.
`ifndef JSON_TOKEN_EXPIRY_EXTRACTOR_MACROS_SVH
`define JSON_TOKEN_EXPIRY_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and off during reset.
`define JTEE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock and off during reset.
`define JTEE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/jtee_pkg.sv -----
// Types and constants shared by the token and expiry extractor modules.
`timescale 1ns / 1ps

package jtee_pkg;

    typedef struct packed {
        logic        func;
        logic        status_ok;
        logic [7:0]  body_byte;
        logic [31:0] now_seconds;
    } t_in;

    typedef struct packed {
        logic        token_char_valid;
        logic [7:0]  token_char;
        logic [7:0]  token_index;
        logic        token_complete;
        logic        expiry_valid;
        logic [31:0] expiry_seconds;
        logic        keys_done;
        logic        token_too_long;
    } t_out;

    typedef struct packed {
        logic        is_start;
        logic        status_ok;
        logic [7:0]  body_byte;
        logic        is_quote;
        logic        is_digit;
        logic [3:0]  digit;
        logic [31:0] now_seconds;
    } t_cls;

    localparam int unsigned Q_DEPTH = 2;

    localparam logic FUNC_START = 1'b0;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] TOKEN_KEY_LEN  = 4'd13;
    localparam logic [3:0] EXPIRY_KEY_LEN = 4'd11;

    function automatic logic [7:0] token_key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = CHAR_QUOTE;
            4'd1:    c = "a";
            4'd2:    c = "c";
            4'd3:    c = "c";
            4'd4:    c = "e";
            4'd5:    c = "s";
            4'd6:    c = "s";
            4'd7:    c = "T";
            4'd8:    c = "o";
            4'd9:    c = "k";
            4'd10:   c = "e";
            4'd11:   c = "n";
            4'd12:   c = CHAR_QUOTE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] expiry_key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = CHAR_QUOTE;
            4'd1:    c = "e";
            4'd2:    c = "x";
            4'd3:    c = "p";
            4'd4:    c = "i";
            4'd5:    c = "r";
            4'd6:    c = "e";
            4'd7:    c = "s";
            4'd8:    c = "I";
            4'd9:    c = "n";
            4'd10:   c = CHAR_QUOTE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/jtee_front.sv -----
// Input side: takes transactions and classifies each body byte for the scanner.
`timescale 1ns / 1ps

module jtee_front
    import jtee_pkg::*;
(
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    input  logic i_q_full,
    output logic o_q_push,
    output t_cls o_q_data
);

    logic [7:0] w_byte;

    assign w_byte     = i_in_data.body_byte;
    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        o_q_data.is_start    = (i_in_data.func == FUNC_START);
        o_q_data.status_ok   = i_in_data.status_ok;
        o_q_data.body_byte   = w_byte;
        o_q_data.is_quote    = (w_byte == CHAR_QUOTE);
        o_q_data.is_digit    = (w_byte >= CHAR_ZERO) && (w_byte <= CHAR_NINE);
        o_q_data.digit       = w_byte[3:0];
        o_q_data.now_seconds = i_in_data.now_seconds;
    end

endmodule

// ----- hw/rtl/jtee_queue.sv -----
// Short queue of classified bytes between the input side and the scanner.
`timescale 1ns / 1ps

module jtee_queue
    import jtee_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_data
);

    localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

    t_cls             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_do_pop;

    assign o_full   = (r_cnt == CNT_FULL);
    assign o_valid  = (r_cnt != '0);
    assign o_data   = r_mem[r_rptr];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/jtee_back.sv -----
// Scanner: key matching, token streaming and expiry accumulation, with the result register.
`timescale 1ns / 1ps

module jtee_back
    import jtee_pkg::*;
#(
    parameter int unsigned TOKEN_CAPACITY = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cls i_q_data,
    output logic o_q_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int unsigned LEN_W = $clog2(TOKEN_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(TOKEN_CAPACITY - 1);

    localparam logic [2:0] ST_FIND_KEY      = 3'd0;
    localparam logic [2:0] ST_TOKEN_WAIT    = 3'd1;
    localparam logic [2:0] ST_TOKEN_COPY    = 3'd2;
    localparam logic [2:0] ST_EXPIRY_WAIT   = 3'd3;
    localparam logic [2:0] ST_EXPIRY_DIGITS = 3'd4;

    logic [2:0]       r_state,    n_state;
    logic [3:0]       r_tk_cnt,   n_tk_cnt;
    logic [3:0]       r_ex_cnt,   n_ex_cnt;
    logic             r_tk_seen,  n_tk_seen;
    logic             r_ex_seen,  n_ex_seen;
    logic [LEN_W-1:0] r_len,      n_len;
    logic [31:0]      r_acc,      n_acc;
    logic             r_resp_ok,  n_resp_ok;
    logic             r_stopped,  n_stopped;
    logic             r_out_valid;
    t_out             r_out,      n_out;

    logic             w_tk_hit;
    logic             w_ex_hit;
    logic [7:0]       w_byte;

    assign w_byte      = i_q_data.body_byte;
    assign o_q_pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_tk_hit = (r_tk_cnt < TOKEN_KEY_LEN) && (w_byte == token_key_char(r_tk_cnt));
    assign w_ex_hit = (r_ex_cnt < EXPIRY_KEY_LEN) && (w_byte == expiry_key_char(r_ex_cnt));

    always_comb begin
        n_state   = r_state;
        n_tk_cnt  = r_tk_cnt;
        n_ex_cnt  = r_ex_cnt;
        n_tk_seen = r_tk_seen;
        n_ex_seen = r_ex_seen;
        n_len     = r_len;
        n_acc     = r_acc;
        n_resp_ok = r_resp_ok;
        n_stopped = r_stopped;
        n_out     = '0;

        if (i_q_data.is_start) begin
            n_state   = ST_FIND_KEY;
            n_tk_cnt  = '0;
            n_ex_cnt  = '0;
            n_tk_seen = 1'b0;
            n_ex_seen = 1'b0;
            n_len     = '0;
            n_acc     = '0;
            n_resp_ok = i_q_data.status_ok;
            n_stopped = 1'b0;
        end else if (r_resp_ok && !r_stopped) begin
            case (r_state)
                ST_FIND_KEY: begin
                    if (!r_tk_seen) begin
                        n_tk_cnt = w_tk_hit ? r_tk_cnt + 4'd1 : 4'd0;
                        if (w_tk_hit && (r_tk_cnt == TOKEN_KEY_LEN - 4'd1)) begin
                            n_tk_seen = 1'b1;
                            n_state   = ST_TOKEN_WAIT;
                        end
                    end
                    if (!r_ex_seen) begin
                        n_ex_cnt = w_ex_hit ? r_ex_cnt + 4'd1 : 4'd0;
                        if (w_ex_hit && (r_ex_cnt == EXPIRY_KEY_LEN - 4'd1)) begin
                            n_ex_seen = 1'b1;
                            n_state   = ST_EXPIRY_WAIT;
                        end
                    end
                end
                ST_TOKEN_WAIT: begin
                    if (i_q_data.is_quote) begin
                        n_state = ST_TOKEN_COPY;
                    end
                end
                ST_TOKEN_COPY: begin
                    if (i_q_data.is_quote) begin
                        n_out.token_complete = 1'b1;
                        if (!r_ex_seen) begin
                            n_ex_cnt = '0;
                            n_state  = ST_FIND_KEY;
                        end else begin
                            n_out.keys_done = 1'b1;
                            n_stopped       = 1'b1;
                        end
                    end else if (r_len < LEN_LIMIT) begin
                        n_out.token_char_valid = 1'b1;
                        n_out.token_char       = w_byte;
                        n_out.token_index      = 8'(r_len);
                        n_len                  = r_len + 1'b1;
                    end else begin
                        n_out.token_too_long = 1'b1;
                        n_stopped            = 1'b1;
                    end
                end
                ST_EXPIRY_WAIT, ST_EXPIRY_DIGITS: begin
                    if (i_q_data.is_digit) begin
                        n_state = ST_EXPIRY_DIGITS;
                        n_acc   = (r_acc << 3) + (r_acc << 1) + {28'd0, i_q_data.digit};
                    end else if (r_state == ST_EXPIRY_DIGITS) begin
                        n_out.expiry_valid   = 1'b1;
                        n_out.expiry_seconds = r_acc + i_q_data.now_seconds;
                        if (!r_tk_seen) begin
                            n_tk_cnt = '0;
                            n_state  = ST_FIND_KEY;
                        end else begin
                            n_out.keys_done = 1'b1;
                            n_stopped       = 1'b1;
                        end
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FIND_KEY;
            r_tk_cnt    <= '0;
            r_ex_cnt    <= '0;
            r_tk_seen   <= 1'b0;
            r_ex_seen   <= 1'b0;
            r_len       <= '0;
            r_acc       <= '0;
            r_resp_ok   <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_state     <= n_state;
                r_tk_cnt    <= n_tk_cnt;
                r_ex_cnt    <= n_ex_cnt;
                r_tk_seen   <= n_tk_seen;
                r_ex_seen   <= n_ex_seen;
                r_len       <= n_len;
                r_acc       <= n_acc;
                r_resp_ok   <= n_resp_ok;
                r_stopped   <= n_stopped;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/json_token_expiry_extractor.sv -----
// Top level of the access token and expiry extractor for authentication response bodies.
// The block takes one transaction per clock cycle while its queue has room and returns
// exactly one result transaction for each. An accepted transaction is written into the
// two-entry queue behind the classifier and then into the scanner, whose key counters, token
// length and expiry accumulator are updated once per byte. A start transaction clears the scan
// and records whether the response status was OK; the scan stops once both keys are handled
// or when the token does not fit in TOKEN_CAPACITY - 1 characters.
`timescale 1ns / 1ps

module json_token_expiry_extractor
    import jtee_pkg::*;
#(
    parameter int unsigned TOKEN_CAPACITY = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic w_q_full;
    logic w_q_push;
    t_cls w_q_wdata;
    logic w_q_pop;
    logic w_q_valid;
    t_cls w_q_rdata;

    jtee_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_wdata)
    );

    jtee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata)
    );

    jtee_back #(
        .TOKEN_CAPACITY (TOKEN_CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_rdata),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hw/rtl/jtee_checker.sv -----
// Port-level checker for the extractor, bound to its top level.
`timescale 1ns / 1ps
`include "json_token_expiry_extractor_macros.svh"

module jtee_checker
    import jtee_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic w_stall;
    logic w_char;
    logic w_other;
    logic w_no_expiry;
    logic w_exp_zero;
    logic w_done;
    logic w_done_cause;

    assign w_stall      = o_out_valid && !i_out_ready;
    assign w_char       = o_out_valid && o_out_data.token_char_valid;
    assign w_other      = o_out_data.expiry_valid || o_out_data.token_complete ||
                          o_out_data.keys_done || o_out_data.token_too_long;
    assign w_no_expiry  = o_out_valid && !o_out_data.expiry_valid;
    assign w_exp_zero   = (o_out_data.expiry_seconds == 32'd0);
    assign w_done       = o_out_valid && o_out_data.keys_done;
    assign w_done_cause = (o_out_data.token_complete || o_out_data.expiry_valid) &&
                          !o_out_data.token_too_long;

    `JTEE_ASSERT_NXT(a_out_hold, w_stall, o_out_valid && $stable(o_out_data), "Result not held.")
    `JTEE_ASSERT_IMP(a_char_alone, w_char, !w_other, "Token character with another event.")
    `JTEE_ASSERT_IMP(a_expiry_zero, w_no_expiry, w_exp_zero, "Stray expiry seconds.")
    `JTEE_ASSERT_IMP(a_done_cause, w_done, w_done_cause, "Stop without a finished value.")

endmodule

bind json_token_expiry_extractor jtee_checker u_jtee_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- verif/tb_top.sv -----
// Testbench for the token and expiry extractor: random response bodies checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import jtee_pkg::*;

    localparam int unsigned TOKEN_CAPACITY = 256;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          HOLD_CYCLES    = 120;
    localparam int          LATENCY_TAIL   = 8;
    localparam int          ITEM_TARGET    = 1950;
    localparam int          MAX_PRINTED    = 20;

    localparam string TOKEN_KEY_S  = "\"accessToken\"";
    localparam string EXPIRY_KEY_S = "\"expiresIn\"";
    localparam string NOISE_CHARS  = "\"aceksTonxpirI:,{} 0123456789";

    typedef enum logic [2:0] {
        SCAN_FIND_KEY,
        SCAN_TOKEN_WAIT,
        SCAN_TOKEN_COPY,
        SCAN_EXPIRY_WAIT,
        SCAN_EXPIRY_DIGITS
    } t_scan_state;

    typedef struct packed {
        logic drain;
        t_in  item;
    } t_body_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    t_body_item pending_items[$];
    t_out       expected_results[$];

    int accepted_cnt = 0;
    int checked_cnt  = 0;
    int total_items  = 0;
    int error_cnt    = 0;
    int response_cnt = 0;
    int cycle_cnt    = 0;
    int stall_cycles = 0;
    int hold_left    = 0;
    logic hold_done  = 1'b0;
    logic in_fired   = 1'b0;

    int token_chars_seen = 0;
    int tokens_closed    = 0;
    int expiries_seen    = 0;
    int scans_completed  = 0;
    int overflows_seen   = 0;

    t_scan_state scan_st;
    logic [3:0]  tok_key_cnt;
    logic [3:0]  exp_key_cnt;
    logic        tok_seen;
    logic        exp_seen;
    int unsigned tok_len;
    logic [31:0] exp_acc;
    logic        resp_ok;
    logic        scan_halted;

    wire quiet = cycle_cnt >= 1500 && cycle_cnt < 2300;

    json_token_expiry_extractor #(
        .TOKEN_CAPACITY(TOKEN_CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic scan_clear();
        scan_st     = SCAN_FIND_KEY;
        tok_key_cnt = '0;
        exp_key_cnt = '0;
        tok_seen    = 1'b0;
        exp_seen    = 1'b0;
        tok_len     = 0;
        exp_acc     = '0;
        resp_ok     = 1'b0;
        scan_halted = 1'b0;
    endtask

    task automatic key_done(output logic both);
        both = 1'b1;
        if (!tok_seen) begin
            tok_key_cnt = '0;
            both = 1'b0;
        end
        if (!exp_seen) begin
            exp_key_cnt = '0;
            both = 1'b0;
        end
    endtask

    task automatic scan_predict(input t_in it, output t_out res);
        logic [7:0] b;
        logic       both;
        res = '0;
        b = it.body_byte;
        if (it.func == FUNC_START) begin
            scan_clear();
            resp_ok = it.status_ok;
        end else if (resp_ok && !scan_halted) begin
            case (scan_st)
                SCAN_FIND_KEY: begin
                    if (!tok_seen) begin
                        if (tok_key_cnt < TOKEN_KEY_LEN && b == TOKEN_KEY_S[tok_key_cnt]) begin
                            tok_key_cnt = tok_key_cnt + 4'd1;
                            if (tok_key_cnt == TOKEN_KEY_LEN) begin
                                tok_seen = 1'b1;
                                scan_st  = SCAN_TOKEN_WAIT;
                            end
                        end else begin
                            tok_key_cnt = '0;
                        end
                    end
                    if (!exp_seen) begin
                        if (exp_key_cnt < EXPIRY_KEY_LEN && b == EXPIRY_KEY_S[exp_key_cnt]) begin
                            exp_key_cnt = exp_key_cnt + 4'd1;
                            if (exp_key_cnt == EXPIRY_KEY_LEN) begin
                                exp_seen = 1'b1;
                                scan_st  = SCAN_EXPIRY_WAIT;
                            end
                        end else begin
                            exp_key_cnt = '0;
                        end
                    end
                end
                SCAN_TOKEN_WAIT: begin
                    if (b == CHAR_QUOTE) scan_st = SCAN_TOKEN_COPY;
                end
                SCAN_TOKEN_COPY: begin
                    if (b == CHAR_QUOTE) begin
                        res.token_complete = 1'b1;
                        key_done(both);
                        if (both) begin
                            res.keys_done = 1'b1;
                            scan_halted   = 1'b1;
                        end else begin
                            scan_st = SCAN_FIND_KEY;
                        end
                    end else if (tok_len < TOKEN_CAPACITY - 1) begin
                        res.token_char_valid = 1'b1;
                        res.token_char       = b;
                        res.token_index      = tok_len[7:0];
                        tok_len++;
                    end else begin
                        res.token_too_long = 1'b1;
                        scan_halted        = 1'b1;
                    end
                end
                SCAN_EXPIRY_WAIT, SCAN_EXPIRY_DIGITS: begin
                    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        scan_st = SCAN_EXPIRY_DIGITS;
                        exp_acc = exp_acc * 32'd10 + {24'd0, b - CHAR_ZERO};
                    end else if (scan_st == SCAN_EXPIRY_DIGITS) begin
                        res.expiry_valid   = 1'b1;
                        res.expiry_seconds = exp_acc + it.now_seconds;
                        key_done(both);
                        if (both) begin
                            res.keys_done = 1'b1;
                            scan_halted   = 1'b1;
                        end else begin
                            scan_st = SCAN_FIND_KEY;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic report_error(input string msg);
        error_cnt++;
        if (error_cnt <= MAX_PRINTED) $display("ERROR: %s", msg);
    endtask

    function automatic logic [31:0] pick_now();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(input logic func, input logic ok, input logic [7:0] b,
                            input logic drain);
        t_body_item s;
        s.drain            = drain;
        s.item.func        = func;
        s.item.status_ok   = ok;
        s.item.body_byte   = b;
        s.item.now_seconds = pick_now();
        pending_items.push_back(s);
    endtask

    task automatic add_start(input logic ok, input logic drain);
        response_cnt++;
        add_item(FUNC_START, ok, 8'($urandom_range(0, 255)), drain);
    endtask

    task automatic add_byte(input logic [7:0] b);
        add_item(~FUNC_START, 1'($urandom_range(0, 1)), b, 1'b0);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(0, 255)));
            else add_byte(NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)]);
        end
    endtask

    task automatic add_broken_key();
        string key;
        int    k;
        key = ($urandom_range(0, 1) == 0) ? TOKEN_KEY_S : EXPIRY_KEY_S;
        k = $urandom_range(1, key.len() - 1);
        add_text(key.substr(0, k - 1));
        add_noise(1);
    endtask

    task automatic add_token(input int len);
        logic [7:0] c;
        add_text(TOKEN_KEY_S);
        case ($urandom_range(0, 3))
            0:       add_text(" : ");
            1:       add_text(":x");
            default: add_text(":");
        endcase
        add_byte(CHAR_QUOTE);
        for (int i = 0; i < len; i++) begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_QUOTE) c = "Z";
            add_byte(c);
        end
        add_byte(CHAR_QUOTE);
    endtask

    task automatic add_expiry();
        logic [7:0] c;
        add_text(EXPIRY_KEY_S);
        add_text(($urandom_range(0, 2) == 0) ? ": a" : ":");
        case ($urandom_range(0, 9))
            0: add_text("4294967295");
            1: add_text("4294967296");
            2: add_text("0");
            default: begin
                for (int i = $urandom_range(1, 12); i > 0; i--)
                    add_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
        endcase
        do c = 8'($urandom_range(0, 255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
        add_byte(c);
    endtask

    function automatic int pick_token_len();
        if ($urandom_range(0, 99) == 0) return 253 + $urandom_range(0, 3);
        return $urandom_range(0, 24);
    endfunction

    task automatic add_response(input int idx);
        int tlen;
        int shape;
        tlen = pick_token_len();
        if (idx == 0) tlen = TOKEN_CAPACITY - 1;
        if (idx == 1) tlen = TOKEN_CAPACITY;
        shape = (idx < 2) ? 9 : $urandom_range(0, 9);
        add_start(idx < 2 || $urandom_range(0, 99) < 90, idx % 10 == 3);
        add_noise($urandom_range(0, 4));
        case (shape)
            0: begin
                add_broken_key();
                add_token(tlen);
                add_noise($urandom_range(0, 3));
                add_expiry();
            end
            1: add_token(tlen);
            2: begin
                add_expiry();
                add_noise($urandom_range(1, 4));
            end
            3: begin
                add_expiry();
                add_noise($urandom_range(0, 2));
                add_token(tlen);
            end
            4: begin
                add_text("\"\"accessToken\"");
                add_broken_key();
                add_text(TOKEN_KEY_S);
                add_text(":\"abc");
            end
            default: begin
                add_token(tlen);
                add_noise($urandom_range(0, 3));
                add_expiry();
            end
        endcase
        add_noise($urandom_range(0, 3));
    endtask

    task automatic build_stimulus();
        int idx;
        // Directed: a failed status, a key missed by the naive matcher, skipped bytes
        // before the first digit, token bytes at both extremes, and bytes after the stop.
        add_start(1'b0, 1'b0);
        add_text("\"a1");
        add_start(1'b1, 1'b1);
        add_text("\"\"accessToken\" ");
        add_text(EXPIRY_KEY_S);
        add_text(":x09");
        add_byte(8'hFF);
        add_text(TOKEN_KEY_S);
        add_byte(CHAR_QUOTE);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CHAR_QUOTE);
        add_byte("a");
        idx = 0;
        while (pending_items.size() < ITEM_TARGET) begin
            add_response(idx);
            idx++;
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fired) begin
            if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 22) &&
                (!pending_items[0].drain || accepted_cnt == checked_cnt)) begin
                in_data  <= pending_items[0].item;
                in_valid <= 1'b1;
                pending_items.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && checked_cnt >= 400) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= quiet || $urandom_range(0, 99) >= 22;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        t_out pred;
        if (!i_rst_n) begin
            scan_clear();
            in_fired     <= 1'b0;
            accepted_cnt <= 0;
            checked_cnt  <= 0;
        end else begin
            in_fired <= in_valid && in_ready;
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           checked_cnt));
                end else begin
                    want = expected_results.pop_front();
                    if (out_data !== want)
                        report_error($sformatf("result %0d: got 0x%0h, expected 0x%0h",
                                               checked_cnt, out_data, want));
                    token_chars_seen += int'(want.token_char_valid);
                    tokens_closed    += int'(want.token_complete);
                    expiries_seen    += int'(want.expiry_valid);
                    scans_completed  += int'(want.keys_done);
                    overflows_seen   += int'(want.token_too_long);
                end
                checked_cnt <= checked_cnt + 1;
            end
            if (in_valid && in_ready) begin
                scan_predict(in_data, pred);
                expected_results.push_back(pred);
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
            cycle_cnt    <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        build_stimulus();
        total_items = pending_items.size();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (checked_cnt != total_items) @(negedge i_clk);
        repeat (LATENCY_TAIL) @(negedge i_clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        $display("Ran %0d responses in %0d transactions: %0d token bytes,",
                 response_cnt, total_items, token_chars_seen);
        $display("%0d tokens closed, %0d expiry values, %0d full scans, %0d overlong, %0d errors.",
                 tokens_closed, expiries_seen, scans_completed, overflows_seen, error_cnt);
        if (error_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
